### hw/rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO.
package brf_pkg;

  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 13;
  localparam int LEVEL_W = 13;
  localparam int STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_DISCARD = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_HAS     = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

endpackage

### hw/rtl/brf_in_if.sv
// Command channel interface: valid/ready plus the command item.
interface brf_in_if;
  logic                       valid;
  logic                       ready;
  logic [brf_pkg::CMD_W-1:0]  command;
  logic [brf_pkg::BYTE_W-1:0] data_byte;
  logic [brf_pkg::CNT_W-1:0]  count;

  modport source (output valid, output command, output data_byte, output count,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input count,
                  output ready);
endinterface

### hw/rtl/brf_out_if.sv
// Result channel interface: valid/ready plus the result item.
interface brf_out_if;
  logic                        valid;
  logic                        ready;
  logic [brf_pkg::BYTE_W-1:0]  read_byte;
  logic                        read_valid;
  logic [brf_pkg::STAT_W-1:0]  status;
  logic                        enough_bytes;
  logic [brf_pkg::LEVEL_W-1:0] fill_level;

  modport source (output valid, output read_byte, output read_valid, output status,
                  output enough_bytes, output fill_level, input ready);
  modport sink   (input valid, input read_byte, input read_valid, input status,
                  input enough_bytes, input fill_level, output ready);
endinterface

### hw/rtl/byte_ring_fifo_core.sv
// Top level of the byte ring FIFO: pointer control, byte store and result register.
//
//  channel  | dir | handshake          | item
//  ---------+-----+--------------------+--------------------------------------------
//  in_ch    | in  | valid/ready        | command, data_byte, count
//  out_ch   | out | valid/ready        | read_byte, read_valid, status, enough_bytes,
//           |     |                    | fill_level
//  cfg_*    | in  | cfg_we, no stall   | capacity_in_use (cfg_wdata)
//
// One item per cycle. The registered result shows in the cycle after the item is
// taken; bytes are a registered read of the byte store RAM, whose port is shared by
// pop and peek. Pointers and level update at acceptance, so the next item sees them.
// in_ch.ready drops only while a result waits on a stalled out_ch.
// Reset empties the FIFO and sets capacity to DEPTH; the byte store is not cleared.
// A capacity write also empties the FIFO.
module byte_ring_fifo_core #(
  parameter int DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  brf_in_if.sink                      in_ch,
  brf_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [brf_pkg::LEVEL_W-1:0] cfg_wdata
);
  import brf_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // pointer / RAM address
  localparam int LW  = $clog2(DEPTH + 1);                 // level and capacity
  localparam int CW  = (LW > CNT_W) ? LW : CNT_W;         // common compare width
  localparam int SW  = CW + 1;                            // pointer + offset sum

  // state
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [LW-1:0] cap_r, cap_nxt;

  // result register
  logic               ov_r, ov_nxt;
  logic               rv_r, rv_nxt;
  status_t            st_r, st_nxt;
  logic               en_r, en_nxt;
  logic [LEVEL_W-1:0] fl_r, fl_nxt;

  // RAM side
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic          accept;
  cmd_t          cmd;
  logic [CW-1:0] cnt_w, lvl_w, cfg_w;
  logic [LW-1:0] cap_eff;
  logic [SW-1:0] adv_sum, adv_pos;
  logic [LW-1:0] rp_inc, wp_inc;

  assign in_ch.ready = !ov_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.command);
  assign cnt_w       = CW'(in_ch.count);
  assign lvl_w       = CW'(lvl_r);
  assign cfg_w       = CW'(cfg_wdata);

  // Register value clamped to 1..DEPTH.
  always_comb begin
    if (cfg_w == '0) begin
      cap_eff = LW'(1);
    end else if (cfg_w > CW'(DEPTH)) begin
      cap_eff = LW'(DEPTH);
    end else begin
      cap_eff = LW'(cfg_w);
    end
  end

  // Read pointer advanced by count, wrapped once; count < capacity when used.
  assign adv_sum = SW'(rp_r) + SW'(in_ch.count);
  assign adv_pos = (adv_sum >= SW'(cap_r)) ? (adv_sum - SW'(cap_r)) : adv_sum;
  assign rp_inc  = LW'(rp_r) + LW'(1);
  assign wp_inc  = LW'(wp_r) + LW'(1);

  always_comb begin
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    lvl_nxt   = lvl_r;
    cap_nxt   = cap_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = rp_r;
    rv_nxt    = 1'b0;
    st_nxt    = ST_OK;
    en_nxt    = 1'b0;

    if (cfg_we) begin
      cap_nxt = cap_eff;
      rp_nxt  = '0;
      wp_nxt  = '0;
      lvl_nxt = '0;
    end else if (accept) begin
      case (cmd)
        CMD_APPEND: begin
          if (lvl_r >= cap_r) begin
            st_nxt = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            wp_nxt  = (wp_inc == cap_r) ? '0 : AW'(wp_inc);
            lvl_nxt = lvl_r + LW'(1);
          end
        end
        CMD_POP: begin
          if (lvl_r == '0) begin
            st_nxt = ST_SHORT;
          end else begin
            ram_re = 1'b1;
            rv_nxt = 1'b1;
            // emptying by consumption rewinds both pointers
            if (lvl_r == LW'(1)) begin
              rp_nxt  = '0;
              wp_nxt  = '0;
              lvl_nxt = '0;
            end else begin
              rp_nxt  = (rp_inc == cap_r) ? '0 : AW'(rp_inc);
              lvl_nxt = lvl_r - LW'(1);
            end
          end
        end
        CMD_PEEK: begin
          if (cnt_w >= lvl_w) begin
            st_nxt = ST_SHORT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(adv_pos);
            rv_nxt    = 1'b1;
          end
        end
        CMD_DISCARD: begin
          if (cnt_w > lvl_w) begin
            st_nxt = ST_SHORT;
          end else if (cnt_w == lvl_w) begin
            rp_nxt  = '0;
            wp_nxt  = '0;
            lvl_nxt = '0;
          end else begin
            rp_nxt  = AW'(adv_pos);
            lvl_nxt = lvl_r - LW'(cnt_w);
          end
        end
        CMD_CLEAR: begin
          rp_nxt  = '0;
          wp_nxt  = '0;
          lvl_nxt = '0;
        end
        CMD_HAS: begin
          en_nxt = (cnt_w <= lvl_w);
        end
        default: begin
          // unused codes: no effect, status ok
        end
      endcase
    end
  end

  assign fl_nxt = LEVEL_W'(lvl_nxt);

  // Result register: loads on accept, drains on out handshake.
  always_comb begin
    if (accept) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= '0;
      lvl_r <= '0;
      cap_r <= LW'(DEPTH);
      ov_r  <= 1'b0;
    end else begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      lvl_r <= lvl_nxt;
      cap_r <= cap_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rv_r <= rv_nxt;
      st_r <= st_nxt;
      en_r <= en_nxt;
      fl_r <= fl_nxt;
    end
  end

  // Byte store; read data holds until the next read, so it tracks the result reg.
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_ch.data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid        = ov_r;
  assign out_ch.read_byte    = rv_r ? ram_rdata : '0;
  assign out_ch.read_valid   = rv_r;
  assign out_ch.status       = st_r;
  assign out_ch.enough_bytes = en_r;
  assign out_ch.fill_level   = fl_r;

endmodule

### hw/rtl/brf_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/brf_chk.sv
// Port-level assertions for the byte ring FIFO, bound to the top level.
module brf_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [brf_pkg::BYTE_W-1:0]  read_byte,
  input logic                        read_valid,
  input logic [brf_pkg::STAT_W-1:0]  status,
  input logic                        enough_bytes,
  input logic [brf_pkg::LEVEL_W-1:0] fill_level
);
  import brf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({read_byte, read_valid, status, enough_bytes, fill_level}))
    else $error("result changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while result register is full and stalled");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && read_valid |-> status == ST_OK && !enough_bytes)
    else $error("returned byte with bad status or has flag");

  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> fill_level != '0 && !read_valid)
    else $error("full status on empty FIFO or with a returned byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind byte_ring_fifo_core brf_chk u_brf_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .read_byte    (out_ch.read_byte),
  .read_valid   (out_ch.read_valid),
  .status       (out_ch.status),
  .enough_bytes (out_ch.enough_bytes),
  .fill_level   (out_ch.fill_level)
);
